// File: rtl/core/cags_pkg.sv
// ----------------------------------------------------------------------------
// cags_pkg
// Shared constants and types for the cave grid smoother: grid size, request
// actions, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package cags_pkg;

    // Grid size; the grid is stored as one word per column, one bit per row
    localparam int GRID_W = 64;
    localparam int GRID_H = 64;
    localparam int X_W    = $clog2(GRID_W);
    localparam int Y_W    = $clog2(GRID_H);

    // Register widths and reset values
    localparam int RULE_W    = 18;
    localparam int PASS_W    = 8;
    localparam int CODE_W    = 8;
    localparam int CFG_W     = 18;
    localparam int CNT_W     = 4;

    localparam logic [RULE_W-1:0] RULE_RST = 18'd174762;
    localparam logic [PASS_W-1:0] PASS_RST = 8'd1;
    localparam logic [CODE_W-1:0] CODE_RST = 8'd35;

    // Rule entry codes
    localparam logic [1:0] RULE_FLOOR = 2'd0;
    localparam logic [1:0] RULE_WALL  = 2'd1;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_RULE      = 2'd0,
        REG_PASSES    = 2'd1,
        REG_WALL_CODE = 2'd2,
        REG_SPARE     = 2'd3
    } cfg_index_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CELL   = 7'b0000010,
        ST_PRIME  = 7'b0000100,
        ST_SMOOTH = 7'b0001000,
        ST_ADV    = 7'b0010000,
        ST_SHIFT  = 7'b0100000,
        ST_RESP   = 7'b1000000
    } state_t;

endpackage

// File: rtl/core/cellular_automaton_grid_smoother_unit.sv
// ----------------------------------------------------------------------------
// cellular_automaton_grid_smoother_unit
// Grid of one-bit wall cells with single-cell write and read requests and a
// run request that applies the neighbour rule in place over the interior.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_action, s_cell_x, s_cell_y, s_is_wall
//  m_        out        m_valid/m_ready    m_cell_value, m_run_done
//  cfg_      in         cfg_we             cfg_index, cfg_wdata
//
//  Write and read requests pass through accept, column read and result.
//  A run request updates one cell per cycle within a column, with the window
//  prime before each pass and a write-back and window shift after each column.
//  The grid lives in a column memory; per-column valid bits make reset clear
//  it at once, with no clearing pass.
//  A new request is taken while a result still waits in the output register;
//  the next result waits in the sequencer until the output register is free.
//
module cellular_automaton_grid_smoother_unit
    import cags_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [5:0]        s_cell_x,
    input  logic [5:0]        s_cell_y,
    input  logic              s_is_wall,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [CODE_W-1:0] m_cell_value,
    output logic              m_run_done
);

    // Configuration registers
    logic [RULE_W-1:0] rule_reg;
    logic [PASS_W-1:0] passes_reg;
    logic [CODE_W-1:0] code_reg;

    // Sequencer state
    state_t            state_reg, state_next;
    action_t           act_reg, act_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [Y_W-1:0]    y_reg, y_next;
    logic              bit_reg, bit_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [1:0]        prime_reg, prime_next;

    // Column window: updated left column, column in work, right column
    logic [GRID_H-1:0] prev_reg, prev_next;
    logic [GRID_H-1:0] cur_reg, cur_next;
    logic [GRID_H-1:0] nxt_reg, nxt_next;

    // Pending result and output register
    logic [CODE_W-1:0] res_value_reg, res_value_next;
    logic              res_done_reg, res_done_next;
    logic              m_valid_reg, m_valid_next;
    logic [CODE_W-1:0] m_value_reg, m_value_next;
    logic              m_done_reg, m_done_next;

    // Column memory and its valid bits
    logic [GRID_H-1:0] grid_mem [GRID_W];
    logic [GRID_W-1:0] col_valid_reg;
    logic [GRID_H-1:0] rd_data_reg;
    logic              rd_ok_reg;
    logic              rd_en, wr_en;
    logic [X_W-1:0]    rd_addr, wr_addr;
    logic [GRID_H-1:0] wr_data;
    logic [GRID_H-1:0] rd_col;

    // Request decode
    logic              s_fire;
    logic              s_inside;
    action_t           s_act;

    // Neighbour count and rule lookup
    logic [Y_W-1:0]    y_dn, y_up;
    logic [CNT_W-1:0]  walls;
    logic [1:0]        entry;
    logic              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign s_act    = action_t'(s_action);
    assign s_inside = (32'(s_cell_x) < GRID_W) && (32'(s_cell_y) < GRID_H);
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_cell_value = m_value_reg;
    assign m_run_done   = m_done_reg;

    // Columns never written read as floor
    assign rd_col = rd_ok_reg ? rd_data_reg : '0;

    assign y_dn  = y_reg - 1'b1;
    assign y_up  = y_reg + 1'b1;
    assign walls = CNT_W'(prev_reg[y_dn]) + CNT_W'(prev_reg[y_reg]) + CNT_W'(prev_reg[y_up])
                 + CNT_W'(cur_reg[y_dn])  + CNT_W'(cur_reg[y_up])
                 + CNT_W'(nxt_reg[y_dn])  + CNT_W'(nxt_reg[y_reg])  + CNT_W'(nxt_reg[y_up]);
    assign entry = rule_reg[{walls, 1'b0} +: 2];

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg   <= RULE_RST;
            passes_reg <= PASS_RST;
            code_reg   <= CODE_RST;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_RULE:      rule_reg   <= cfg_wdata[RULE_W-1:0];
                REG_PASSES:    passes_reg <= cfg_wdata[PASS_W-1:0];
                REG_WALL_CODE: code_reg   <= cfg_wdata[CODE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        bit_next       = bit_reg;
        pass_next      = pass_reg;
        prime_next     = prime_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        res_value_next = res_value_reg;
        res_done_next  = res_done_reg;
        rd_en          = 1'b0;
        rd_addr        = x_reg;
        wr_en          = 1'b0;
        wr_addr        = x_reg;
        wr_data        = cur_reg;

        case (state_reg)
            // Take a request; start the column read for cell accesses
            ST_IDLE: begin
                if (s_fire) begin
                    act_next       = s_act;
                    x_next         = X_W'(s_cell_x);
                    y_next         = Y_W'(s_cell_y);
                    bit_next       = s_is_wall;
                    res_value_next = '0;
                    res_done_next  = 1'b0;
                    case (s_act)
                        ACT_WRITE, ACT_READ: begin
                            if (s_inside) begin
                                rd_en      = 1'b1;
                                rd_addr    = X_W'(s_cell_x);
                                state_next = ST_CELL;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        ACT_RUN: begin
                            res_done_next = 1'b1;
                            if (passes_reg == '0) begin
                                state_next = ST_RESP;
                            end else begin
                                pass_next  = passes_reg;
                                prime_next = '0;
                                state_next = ST_PRIME;
                            end
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end

            // Modify and write back, or pick out the read bit
            ST_CELL: begin
                if (act_reg == ACT_WRITE) begin
                    wr_en          = 1'b1;
                    wr_data        = rd_col;
                    wr_data[y_reg] = bit_reg;
                end else begin
                    res_value_next = rd_col[y_reg] ? code_reg : '0;
                end
                state_next = ST_RESP;
            end

            // Load columns 0, 1 and 2 into the window
            ST_PRIME: begin
                if (prime_reg != 2'd3) begin
                    rd_en   = 1'b1;
                    rd_addr = X_W'(prime_reg);
                end
                if (prime_reg != 2'd0) begin
                    prev_next = cur_reg;
                    cur_next  = nxt_reg;
                    nxt_next  = rd_col;
                end
                prime_next = prime_reg + 2'd1;
                if (prime_reg == 2'd3) begin
                    x_next     = X_W'(1);
                    y_next     = Y_W'(1);
                    state_next = ST_SMOOTH;
                end
            end

            // Update one cell of the middle column in place
            ST_SMOOTH: begin
                if (entry == RULE_WALL) begin
                    cur_next[y_reg] = 1'b1;
                end else if (entry == RULE_FLOOR) begin
                    cur_next[y_reg] = 1'b0;
                end
                if (y_reg == Y_W'(GRID_H - 2)) begin
                    state_next = ST_ADV;
                end else begin
                    y_next = y_up;
                end
            end

            // Write the finished column back; fetch the next right column, or end the pass at the last interior column
            ST_ADV: begin
                wr_en = 1'b1;
                if (x_reg == X_W'(GRID_W - 2)) begin
                    if (pass_reg == PASS_W'(1)) begin
                        state_next = ST_RESP;
                    end else begin
                        pass_next  = pass_reg - 1'b1;
                        prime_next = '0;
                        state_next = ST_PRIME;
                    end
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = x_reg + X_W'(2);
                    state_next = ST_SHIFT;
                end
            end

            // Slide the window one column right
            ST_SHIFT: begin
                prev_next  = cur_reg;
                cur_next   = nxt_reg;
                nxt_next   = rd_col;
                x_next     = x_reg + 1'b1;
                y_next     = Y_W'(1);
                state_next = ST_SMOOTH;
            end

            // Hold the result until the output register is free
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_done_next  = m_done_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_RESP && out_free) begin
            m_valid_next = 1'b1;
            m_value_next = res_value_reg;
            m_done_next  = res_done_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            col_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (wr_en) begin
                col_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= col_valid_reg[rd_addr];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        bit_reg       <= bit_next;
        pass_reg      <= pass_next;
        prime_reg     <= prime_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        nxt_reg       <= nxt_next;
        res_value_reg <= res_value_next;
        res_done_reg  <= res_done_next;
        m_value_reg   <= m_value_next;
        m_done_reg    <= m_done_next;
    end

    // Column memory with a registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // Read and write never meet on one column in the same cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("column read and write collide");

    // Smoothing never writes a border column
    a_interior_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADV) |-> (x_reg >= X_W'(1) && x_reg <= X_W'(GRID_W - 2)))
        else $error("smoothing wrote a border column");

    // Smoothing stays on interior rows
    a_interior_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SMOOTH) |-> (y_reg >= Y_W'(1) && y_reg <= Y_W'(GRID_H - 2)))
        else $error("smoothing left the interior rows");

    // A run result never carries a cell value
    a_done_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_run_done) |-> (m_cell_value == '0))
        else $error("run result carries a cell value");

    // A loaded result appears on the output the cycle after
    a_resp_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not delivered to output register");

endmodule
